FILE: design/spd_pkg.sv
`default_nettype none

package spd_pkg;

    // Kind of data carried by one result.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_NAME    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // Packet status codes.
    localparam logic [1:0] ST_BUSY       = 2'd0;
    localparam logic [1:0] ST_OK         = 2'd1;
    localparam logic [1:0] ST_WRONG_TYPE = 2'd2;
    localparam logic [1:0] ST_MALFORMED  = 2'd3;

    // One parser result, valid when have is set.
    typedef struct packed {
        logic        have;
        logic [1:0]  byte_kind;
        logic [7:0]  out_byte;
        logic [31:0] item_number;
        logic        item_end;
        logic [1:0]  packet_status;
    } spd_result_t;

endpackage

`default_nettype wire

FILE: design/spd_if.sv
`default_nettype none

// Byte channel into the deframer.
interface spd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

// Result channel out of the deframer.
interface spd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_kind;
    logic [7:0]  out_byte;
    logic [31:0] item_number;
    logic        item_end;
    logic [1:0]  packet_status;

    modport source (output valid, output byte_kind, output out_byte, output item_number,
                    output item_end, output packet_status, input ready);
    modport sink (input valid, input byte_kind, input out_byte, input item_number,
                  input item_end, input packet_status, output ready);
endinterface

`default_nettype wire

FILE: design/sync_packet_deframer.sv
// Channel  | Direction | Transfer carries
// ---------+-----------+--------------------------------------------------------
// in_ch    | sink      | data_byte, buffer_end
// out_ch   | source    | byte_kind, out_byte, item_number, item_end, packet_status
// cfg      | write     | cfg_wr_en, cfg_wr_data (expected packet type)
//
// One byte is taken per cycle while out_ch is not stalled; its result, if any, appears in the cycle after.
// The rate is set by the single result register: a new byte is taken whenever
// that register is empty or is being read in the same cycle.
// Reset (rst_n low, asynchronous) clears the parser, the output valid and the
// expected type. A stall on out_ch holds in_ch.ready low until the result moves.

`default_nettype none

module sync_packet_deframer
    import spd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    spd_in_if.sink           in_ch,
    spd_out_if.source        out_ch
);

    logic [31:0] expected_type_reg;
    logic        out_valid_reg;
    spd_result_t out_reg;
    spd_result_t result;
    logic        in_fire;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_type_reg <= 32'd0;
        end
        else if (cfg_wr_en)
        begin
            expected_type_reg <= cfg_wr_data;
        end
    end

    // Input transfer whenever the result register can take a new value.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    spd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (in_fire),
        .data_byte     (in_ch.data_byte),
        .buffer_end    (in_ch.buffer_end),
        .expected_type (expected_type_reg),
        .result        (result)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= result.have;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.byte_kind     = out_reg.byte_kind;
    assign out_ch.out_byte      = out_reg.out_byte;
    assign out_ch.item_number   = out_reg.item_number;
    assign out_ch.item_end      = out_reg.item_end;
    assign out_ch.packet_status = out_reg.packet_status;

`ifndef SYNTH
    // An in-progress result always carries a data byte or closes an item.
    a_busy_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.packet_status == ST_BUSY
        |-> out_reg.byte_kind != KIND_NONE || out_reg.item_end)
        else $error("in-progress result without data or item end");

    // A rejected packet reports no data and closes no item.
    a_wrong_type_bare: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.packet_status == ST_WRONG_TYPE
        |-> out_reg.byte_kind == KIND_NONE && !out_reg.item_end)
        else $error("wrong-type result carries data");

    // A result without data carries a zero byte.
    a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.byte_kind == KIND_NONE |-> out_reg.out_byte == 8'd0)
        else $error("nonzero byte on a result without data");
`endif

endmodule

`default_nettype wire

FILE: design/spd_parser.sv
`default_nettype none

module spd_parser
    import spd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  data_byte,
    input  wire logic        buffer_end,
    input  wire logic [31:0] expected_type,
    output spd_result_t      result
);

    typedef enum logic [2:0] {
        PH_HLEN  = 3'd0,
        PH_TYPE  = 3'd1,
        PH_COUNT = 3'd2,
        PH_NLEN  = 3'd3,
        PH_NAME  = 3'd4,
        PH_PLEN  = 3'd5,
        PH_PAY   = 3'd6,
        PH_DONE  = 3'd7
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  field_idx_reg, field_idx_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic [31:0] items_expected_reg, items_expected_next;
    logic [31:0] items_finished_reg, items_finished_next;
    logic [31:0] bytes_remaining_reg, bytes_remaining_next;

    logic [31:0] shifted;
    logic [31:0] finished_inc;
    logic [31:0] remaining_dec;

    assign shifted       = {field_shift_reg[23:0], data_byte};
    assign finished_inc  = items_finished_reg + 32'd1;
    assign remaining_dec = bytes_remaining_reg - 32'd1;

    // Next state and the result for the byte being transferred.
    always_comb
    begin
        phase_next           = phase_reg;
        field_idx_next       = field_idx_reg;
        field_shift_next     = field_shift_reg;
        items_expected_next  = items_expected_reg;
        items_finished_next  = items_finished_reg;
        bytes_remaining_next = bytes_remaining_reg;

        result.have          = 1'b0;
        result.byte_kind     = KIND_NONE;
        result.out_byte      = 8'd0;
        result.item_number   = items_finished_reg;
        result.item_end      = 1'b0;
        result.packet_status = ST_BUSY;

        unique case (phase_reg)
            PH_DONE:
            begin
                // Trailing bytes are dropped.
            end
            PH_NAME:
            begin
                result.have          = 1'b1;
                result.byte_kind     = KIND_NAME;
                result.out_byte      = data_byte;
                bytes_remaining_next = remaining_dec;
                if (remaining_dec == 32'd0)
                begin
                    phase_next = PH_PLEN;
                end
            end
            PH_PAY:
            begin
                result.have          = 1'b1;
                result.byte_kind     = KIND_PAYLOAD;
                result.out_byte      = data_byte;
                bytes_remaining_next = remaining_dec;
                if (remaining_dec == 32'd0)
                begin
                    result.item_end     = 1'b1;
                    items_finished_next = finished_inc;
                    if (finished_inc == items_expected_reg)
                    begin
                        phase_next           = PH_DONE;
                        result.packet_status = ST_OK;
                    end
                    else
                    begin
                        phase_next = PH_NLEN;
                    end
                end
            end
            PH_HLEN, PH_TYPE, PH_COUNT, PH_NLEN, PH_PLEN:
            begin
                // A 32-bit big-endian field collects one byte per transfer.
                field_shift_next = shifted;
                if (field_idx_reg != 2'd3)
                begin
                    field_idx_next = field_idx_reg + 2'd1;
                end
                else
                begin
                    field_idx_next = 2'd0;
                    unique case (phase_reg)
                        PH_HLEN:
                        begin
                            phase_next = PH_TYPE;
                        end
                        PH_TYPE:
                        begin
                            if (shifted != expected_type)
                            begin
                                result.have          = 1'b1;
                                result.packet_status = ST_WRONG_TYPE;
                                phase_next           = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_COUNT;
                            end
                        end
                        PH_COUNT:
                        begin
                            items_expected_next = shifted;
                            items_finished_next = 32'd0;
                            if (shifted == 32'd0)
                            begin
                                result.have          = 1'b1;
                                result.packet_status = ST_OK;
                                phase_next           = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_NLEN;
                            end
                        end
                        PH_NLEN:
                        begin
                            bytes_remaining_next = shifted;
                            phase_next = (shifted != 32'd0) ? PH_NAME : PH_PLEN;
                        end
                        PH_PLEN:
                        begin
                            bytes_remaining_next = shifted;
                            if (shifted == 32'd0)
                            begin
                                // Empty payload closes the item at once.
                                result.have         = 1'b1;
                                result.item_end     = 1'b1;
                                items_finished_next = finished_inc;
                                if (finished_inc == items_expected_reg)
                                begin
                                    phase_next           = PH_DONE;
                                    result.packet_status = ST_OK;
                                end
                                else
                                begin
                                    phase_next = PH_NLEN;
                                end
                            end
                            else
                            begin
                                phase_next = PH_PAY;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        endcase

        // The last byte of a buffer reports an unfinished packet and clears state.
        if (buffer_end)
        begin
            if (phase_next != PH_DONE)
            begin
                result.have = 1'b1;
                if (phase_next == PH_HLEN || phase_next == PH_TYPE)
                begin
                    result.packet_status = (expected_type != 32'd0) ? ST_WRONG_TYPE
                                                                    : ST_MALFORMED;
                end
                else
                begin
                    result.packet_status = ST_MALFORMED;
                end
            end
            phase_next           = PH_HLEN;
            field_idx_next       = 2'd0;
            field_shift_next     = 32'd0;
            items_expected_next  = 32'd0;
            items_finished_next  = 32'd0;
            bytes_remaining_next = 32'd0;
        end
    end

    // Parser state advances on every transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HLEN;
            field_idx_reg       <= 2'd0;
            field_shift_reg     <= 32'd0;
            items_expected_reg  <= 32'd0;
            items_finished_reg  <= 32'd0;
            bytes_remaining_reg <= 32'd0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            field_idx_reg       <= field_idx_next;
            field_shift_reg     <= field_shift_next;
            items_expected_reg  <= items_expected_next;
            items_finished_reg  <= items_finished_next;
            bytes_remaining_reg <= bytes_remaining_next;
        end
    end

endmodule

`default_nettype wire
